// ----- hw/rtl/mct_pkg.sv -----
// Shared types, character codes and helpers for the Morse tree codec.
`timescale 1ns / 1ps

package mct_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] symbol;
        logic       msg_last;
        logic [5:0] code_bits;
        logic [2:0] code_length;
        logic [7:0] entry_char;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       run_last;
        logic       message_end;
    } result_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_char;
        logic       finish;
        logic       last;
    } emit_cmd_t;

    // Heap index of a code: a leading one followed by the symbols, first symbol highest.
    function automatic logic [7:0] load_index(input logic [5:0] bits, input logic [2:0] len);
        logic [7:0] idx;
        logic [6:0] code;
        idx  = 8'd1;
        code = {1'b0, bits};
        for (int i = 0; i < 7; i++)
        begin
            if (3'(i) < len)
            begin
                idx = {idx[6:0], code[i]};
            end
        end
        return idx;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

// ----- hw/rtl/morse_trie_codec.sv -----
// Top level: sequencer that walks and scans the Morse tree table, one step per cycle.
//
//   channel   signals                     handshake
//   item      start, busy, item           taken when start is high and busy is low
//   result    result_strobe, result       a single-cycle strobe per result, no back-pressure
//
// After reset the table is cleared one entry per cycle, all 2 << MAX_DEPTH entries
// (128 by default), with busy high. A load or an unused op is taken without leaving
// idle, and busy stays low. A decode item waits on the registered table read when it
// closes a letter and puts out its results in turn. An encode item first looks at the
// character, scans the table one entry per cycle, then normalizes the index and sends
// its symbols, and it also closes an open letter when it ends the message. The
// receiver cannot stall.
`timescale 1ns / 1ps

module morse_trie_codec #(
    parameter int MAX_DEPTH = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mct_pkg::item_t   item,
    output mct_pkg::result_t result,
    output logic             result_strobe
);

    localparam int AW = MAX_DEPTH + 1;
    localparam int TS = 2 << MAX_DEPTH;
    localparam int RW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DEC_WORD, ST_DEC_SYM, ST_FIN, ST_LAST,
        ST_ENC_START, ST_ENC_SP, ST_SCAN, ST_NORM, ST_ENC_SYM, ST_PUT, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    mct_pkg::item_t     item_reg, item_next;
    logic [AW-1:0]      walk_reg, walk_next;
    logic               token_open_reg, token_open_next;
    logic               ovf_reg, ovf_next;
    logic               word_pend_reg, word_pend_next;
    logic               held_reg, held_next;
    logic [7:0]         put_ch_reg, put_ch_next;
    logic [7:0]         ch_reg, ch_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW:0]        scan_reg, scan_next;
    logic [AW-1:0]      prev_reg, prev_next;
    logic               chk_reg, chk_next;
    logic [AW-1:0]      code_reg, code_next;
    logic [RW-1:0]      rem_reg, rem_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;
    mct_pkg::emit_cmd_t emit_cmd;

    logic [AW+7:0]      load_idx_wide;
    logic [7:0]         sym_up;
    logic [7:0]         fin_char;
    logic               load_ok;

    assign load_idx_wide = {{AW{1'b0}}, mct_pkg::load_index(item.code_bits, item.code_length)};
    assign load_ok       = (32'(item.code_length) <= MAX_DEPTH);
    assign sym_up        = mct_pkg::to_upper(item_reg.symbol);
    assign fin_char      = ovf_reg ? mct_pkg::CH_NUL : ram_rdata;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        item_next       = item_reg;
        walk_next       = walk_reg;
        token_open_next = token_open_reg;
        ovf_next        = ovf_reg;
        word_pend_next  = word_pend_reg;
        held_next       = held_reg;
        put_ch_next     = put_ch_reg;
        ch_next         = ch_reg;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        prev_next       = prev_reg;
        chk_next        = chk_reg;
        code_next       = code_reg;
        rem_next        = rem_reg;
        ram_we          = 1'b0;
        ram_waddr       = load_idx_wide[AW-1:0];
        ram_wdata       = item.entry_char;
        ram_raddr       = (state_reg == ST_SCAN) ? scan_reg[AW-1:0] : walk_reg;
        emit_cmd        = '{push: 1'b0, push_char: mct_pkg::CH_NUL, finish: 1'b0, last: 1'b0};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = mct_pkg::CH_NUL;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(TS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    case (item.op)
                        mct_pkg::OP_LOAD:   ram_we = load_ok;
                        mct_pkg::OP_DECODE: state_next = ST_DEC_WORD;
                        mct_pkg::OP_ENCODE: state_next = ST_ENC_START;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DEC_WORD:
            begin
                if (word_pend_reg)
                begin
                    word_pend_next = 1'b0;
                    put_ch_next    = mct_pkg::CH_SPACE;
                    ret_next       = ST_DEC_SYM;
                    state_next     = ST_PUT;
                end
                else
                begin
                    state_next = ST_DEC_SYM;
                end
            end
            ST_DEC_SYM:
            begin
                if (item_reg.symbol == mct_pkg::CH_SPACE || item_reg.symbol == mct_pkg::CH_SLASH)
                begin
                    if (item_reg.symbol == mct_pkg::CH_SLASH)
                    begin
                        word_pend_next = 1'b1;
                    end
                    // The table read of the current node was issued this cycle.
                    ret_next   = ST_LAST;
                    state_next = token_open_reg ? ST_FIN : ST_LAST;
                end
                else
                begin
                    token_open_next = 1'b1;
                    if (item_reg.symbol == mct_pkg::CH_DOT || item_reg.symbol == mct_pkg::CH_DASH)
                    begin
                        if (walk_reg[AW-1])
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            walk_next = {walk_reg[AW-2:0], item_reg.symbol == mct_pkg::CH_DASH};
                        end
                    end
                    state_next = ST_LAST;
                end
            end
            ST_FIN:
            begin
                put_ch_next     = (fin_char == mct_pkg::CH_NUL) ? mct_pkg::CH_QUERY : fin_char;
                walk_next       = AW'(1);
                token_open_next = 1'b0;
                ovf_next        = 1'b0;
                state_next      = ST_PUT;
            end
            ST_LAST:
            begin
                ret_next   = ST_DONE;
                state_next = (item_reg.msg_last && token_open_reg) ? ST_FIN : ST_DONE;
            end
            ST_ENC_START:
            begin
                ch_next = sym_up;
                if (item_reg.symbol == mct_pkg::CH_SPACE)
                begin
                    put_ch_next = mct_pkg::CH_SLASH;
                    ret_next    = ST_ENC_SP;
                    state_next  = ST_PUT;
                end
                else if (!mct_pkg::is_alnum(sym_up))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_next  = (AW + 1)'(1);
                    chk_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_ENC_SP:
            begin
                put_ch_next = mct_pkg::CH_SPACE;
                ret_next    = ST_LAST;
                state_next  = ST_PUT;
            end
            ST_SCAN:
            begin
                // One entry is addressed per cycle; the compare sees the entry addressed before.
                if (chk_reg && ram_rdata == ch_reg)
                begin
                    code_next  = prev_reg;
                    rem_next   = RW'(MAX_DEPTH);
                    state_next = ST_NORM;
                end
                else if (scan_reg[AW])
                begin
                    put_ch_next = mct_pkg::CH_QUERY;
                    ret_next    = ST_LAST;
                    state_next  = ST_PUT;
                end
                else
                begin
                    prev_next = scan_reg[AW-1:0];
                    chk_next  = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_NORM:
            begin
                if (code_reg[AW-1])
                begin
                    state_next = ST_ENC_SYM;
                end
                else
                begin
                    code_next = {code_reg[AW-2:0], 1'b0};
                    rem_next  = rem_reg - 1'b1;
                end
            end
            ST_ENC_SYM:
            begin
                state_next = ST_PUT;
                if (rem_reg == '0)
                begin
                    put_ch_next = mct_pkg::CH_SPACE;
                    ret_next    = ST_LAST;
                end
                else
                begin
                    put_ch_next = code_reg[AW-2] ? mct_pkg::CH_DASH : mct_pkg::CH_DOT;
                    ret_next    = ST_ENC_SYM;
                    code_next   = {code_reg[AW-2:0], 1'b0};
                    rem_next    = rem_reg - 1'b1;
                end
            end
            ST_PUT:
            begin
                // A held space goes out first; a new space is only held back.
                if (held_reg)
                begin
                    emit_cmd.push      = 1'b1;
                    emit_cmd.push_char = mct_pkg::CH_SPACE;
                    if (put_ch_reg == mct_pkg::CH_SPACE)
                    begin
                        state_next = ret_reg;
                    end
                    else
                    begin
                        held_next = 1'b0;
                    end
                end
                else
                begin
                    if (put_ch_reg == mct_pkg::CH_SPACE)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        emit_cmd.push      = 1'b1;
                        emit_cmd.push_char = put_ch_reg;
                    end
                    state_next = ret_reg;
                end
            end
            ST_DONE:
            begin
                emit_cmd.finish = 1'b1;
                emit_cmd.last   = item_reg.msg_last;
                if (item_reg.msg_last)
                begin
                    held_next       = 1'b0;
                    word_pend_next  = 1'b0;
                    walk_next       = AW'(1);
                    token_open_next = 1'b0;
                    ovf_next        = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            ret_reg        <= ST_IDLE;
            walk_reg       <= AW'(1);
            token_open_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            word_pend_reg  <= 1'b0;
            held_reg       <= 1'b0;
            clr_reg        <= '0;
            scan_reg       <= '0;
            chk_reg        <= 1'b0;
            rem_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            walk_reg       <= walk_next;
            token_open_reg <= token_open_next;
            ovf_reg        <= ovf_next;
            word_pend_reg  <= word_pend_next;
            held_reg       <= held_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            chk_reg        <= chk_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        put_ch_reg <= put_ch_next;
        ch_reg     <= ch_next;
        prev_reg   <= prev_next;
        code_reg   <= code_next;
    end

    assign busy = (state_reg != ST_IDLE);

    mct_ram #(
        .WIDTH(8),
        .DEPTH(TS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    mct_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (emit_cmd),
        .result       (result),
        .result_strobe(result_strobe)
    );

`ifndef SYNTHESIS
    a_strobe_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result strobe without a busy cycle before it");

    a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg != '0)
        else $error("tree walk left the heap index space");

    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == mct_pkg::OP_LOAD) |=> !busy)
        else $error("load item held the block busy");

    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!result_strobe && !emit_cmd.push))
        else $error("result during table clearing pass");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("table written during encode scan");
`endif

endmodule

// ----- hw/rtl/mct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mct_emit.sv -----
// Result stage: holds one result back so the last one of an item can be marked.
`timescale 1ns / 1ps

module mct_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  mct_pkg::emit_cmd_t cmd,
    output mct_pkg::result_t   result,
    output logic               result_strobe
);

    logic                      pend_valid_reg, pend_valid_next;
    logic [7:0]                pend_char_reg, pend_char_next;
    logic [mct_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    mct_pkg::result_t          out_reg, out_next;
    logic                      strobe_reg, strobe_next;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        strobe_next     = 1'b0;
        if (cmd.push)
        begin
            // Results beyond the per-item limit are dropped.
            if (cnt_reg < mct_pkg::CNT_W'(mct_pkg::MAX_RESULTS))
            begin
                cnt_next = cnt_reg + 1'b1;
                if (pend_valid_reg)
                begin
                    strobe_next = 1'b1;
                    out_next    = '{out_char: pend_char_reg, has_char: 1'b1,
                                    run_last: 1'b0, message_end: 1'b0};
                end
                pend_valid_next = 1'b1;
                pend_char_next  = cmd.push_char;
            end
        end
        else if (cmd.finish)
        begin
            if (pend_valid_reg)
            begin
                strobe_next = 1'b1;
                out_next    = '{out_char: pend_char_reg, has_char: 1'b1,
                                run_last: 1'b1, message_end: cmd.last};
            end
            else if (cmd.last)
            begin
                strobe_next = 1'b1;
                out_next    = '{out_char: mct_pkg::CH_NUL, has_char: 1'b0,
                                run_last: 1'b1, message_end: 1'b1};
            end
            pend_valid_next = 1'b0;
            cnt_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        out_reg       <= out_next;
    end

    assign result        = out_reg;
    assign result_strobe = strobe_reg;

endmodule
